// ===== rtl/mep_pkg.sv =====
// shared types, register indexes and fixed-point helpers of the mandelbrot pixel unit
package mep_pkg;

    // fixed-point format, signed Q4.28
    localparam int unsigned FRAC_BITS = 28;

    // default image size in pixels
    localparam int unsigned DEF_IMAGE_WIDTH  = 1024;
    localparam int unsigned DEF_IMAGE_HEIGHT = 1024;

    // entries of the queue between the mapper and the iteration engine
    localparam int unsigned QUEUE_DEPTH = 2;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_X      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_RAD2 = 3'd5;

    // register reset values
    localparam logic signed [31:0] RST_CENTER_X    = -32'sd134217728;
    localparam logic signed [31:0] RST_CENTER_Y    = 32'sd0;
    localparam logic [30:0]        RST_STEP_X      = 31'd1048576;
    localparam logic [30:0]        RST_STEP_Y      = 31'd1048576;
    localparam logic [15:0]        RST_ITER_LIMIT  = 16'd256;
    localparam logic [30:0]        RST_ESCAPE_RAD2 = 31'd1073741824;

    // saturation bounds for the signed 32-bit range
    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    // input item
    typedef struct packed {
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
    } mep_in_t;

    // result item
    typedef struct packed {
        logic [10:0] out_pixel_x;
        logic [10:0] out_pixel_y;
        logic [15:0] escape_count;
        logic        in_set;
    } mep_out_t;

    // configuration registers as seen by front and back
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        step_x;
        logic [30:0]        step_y;
        logic [15:0]        iteration_limit;
        logic [30:0]        escape_radius_squared;
    } mep_cfg_t;

    // mapped pixel waiting for iteration
    typedef struct packed {
        logic [10:0]        pixel_x;
        logic [10:0]        pixel_y;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } mep_job_t;

    // queue status seen by the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } mep_qstat_t;

    // clamp a wide signed value into the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[31:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/mandelbrot_escape_time_pixel_unit.sv =====
// top level of the mandelbrot escape-time pixel unit
//
// One input item carries a pixel index pair. The front maps it to a complex
// point c in signed Q4.28 and places it in a two-entry queue; the back pulls
// points from the queue and iterates z = z^2 + c from z = c until |z|^2
// reaches escape_radius_squared or iteration_limit passes are done, then
// returns the pixel indices, the pass count and the in-set flag.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. Configuration is written through cfg_we, cfg_index and
// cfg_data while the unit is idle; unknown indexes are ignored.
// Each item passes through the mapping register in the front, the queue,
// the engine and the output register. The engine makes each pass in two
// states, S_MUL for the three products and S_UPD for the escape test and
// z update, and moves the result into the output register in S_DONE.
// The engine handles one item at a time, so it takes no new point from the
// queue until the last result has gone into the output register.
// Reset clears all valid state and loads the default view registers.
// A stalled result stays in the output register; the engine and queue keep
// working until they fill, then the input stall rises.
module mandelbrot_escape_time_pixel_unit #(
    parameter int unsigned IMAGE_WIDTH  = mep_pkg::DEF_IMAGE_WIDTH,
    parameter int unsigned IMAGE_HEIGHT = mep_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  mep_pkg::mep_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output mep_pkg::mep_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [mep_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mep_pkg::*;

    mep_cfg_t   cfg_reg;
    mep_cfg_t   cfg_next;
    mep_qstat_t qstat;
    mep_job_t   push_data;
    mep_job_t   pop_data;
    logic       push;
    logic       pop;

    // configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTER_X:    cfg_next.center_x = $signed(cfg_data);
                REG_CENTER_Y:    cfg_next.center_y = $signed(cfg_data);
                REG_STEP_X:      cfg_next.step_x = cfg_data[30:0];
                REG_STEP_Y:      cfg_next.step_y = cfg_data[30:0];
                REG_ITER_LIMIT:  cfg_next.iteration_limit = cfg_data[15:0];
                REG_ESCAPE_RAD2: cfg_next.escape_radius_squared = cfg_data[30:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x              <= RST_CENTER_X;
            cfg_reg.center_y              <= RST_CENTER_Y;
            cfg_reg.step_x                <= RST_STEP_X;
            cfg_reg.step_y                <= RST_STEP_Y;
            cfg_reg.iteration_limit       <= RST_ITER_LIMIT;
            cfg_reg.escape_radius_squared <= RST_ESCAPE_RAD2;
        end
        else
            cfg_reg <= cfg_next;
    end

    // coordinate mapping
    mep_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    mep_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    // iteration engine
    mep_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .job       (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/mep_front.sv =====
// front end: accepts pixel items and maps them to complex points
module mep_front #(
    parameter int unsigned IMAGE_WIDTH  = mep_pkg::DEF_IMAGE_WIDTH,
    parameter int unsigned IMAGE_HEIGHT = mep_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mep_pkg::mep_in_t   in_data,
    input  mep_pkg::mep_cfg_t  cfg,
    input  mep_pkg::mep_qstat_t qstat,
    output logic               push,
    output mep_pkg::mep_job_t  push_data
);
    import mep_pkg::*;

    localparam int unsigned PROD_W = 45;
    localparam logic signed [12:0] SIZE_X = 13'(IMAGE_WIDTH);
    localparam logic signed [12:0] SIZE_Y = 13'(IMAGE_HEIGHT);

    logic                      hold_valid_reg;
    logic                      hold_valid_next;
    logic [10:0]               px_reg;
    logic [10:0]               py_reg;
    logic signed [PROD_W-1:0]  prod_x_reg;
    logic signed [PROD_W-1:0]  prod_y_reg;
    logic signed [12:0]        off2_x;
    logic signed [12:0]        off2_y;
    logic                      accept;
    logic signed [PROD_W-1:0]  half_x;
    logic signed [PROD_W-1:0]  half_y;
    logic signed [63:0]        sum_x;
    logic signed [63:0]        sum_y;

    // one item held between the multiply and the add
    assign push     = hold_valid_reg && !qstat.full;
    assign in_stall = hold_valid_reg && !push;
    assign accept   = in_valid && !in_stall;

    // doubled offset from the image middle
    assign off2_x = $signed({1'b0, in_data.pixel_x, 1'b0}) - SIZE_X;
    assign off2_y = $signed({1'b0, in_data.pixel_y, 1'b0}) - SIZE_Y;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (push)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    // offset times step, exact
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg     <= in_data.pixel_x;
            py_reg     <= in_data.pixel_y;
            prod_x_reg <= PROD_W'(off2_x * $signed({1'b0, cfg.step_x}));
            prod_y_reg <= PROD_W'(off2_y * $signed({1'b0, cfg.step_y}));
        end
    end

    // halve with floor, add center, clamp
    always_comb
    begin
        half_x = prod_x_reg >>> 1;
        half_y = prod_y_reg >>> 1;
        sum_x  = 64'(half_x) + 64'(cfg.center_x);
        sum_y  = 64'(half_y) + 64'(cfg.center_y);
        push_data.pixel_x = px_reg;
        push_data.pixel_y = py_reg;
        push_data.cx      = sat32(sum_x);
        push_data.cy      = sat32(sum_y);
    end

endmodule

// ===== rtl/mep_queue.sv =====
// short queue of mapped items between front and back
module mep_queue #(
    parameter int unsigned DEPTH = mep_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mep_pkg::mep_job_t   push_data,
    input  logic                pop,
    output mep_pkg::mep_job_t   pop_data,
    output mep_pkg::mep_qstat_t qstat
);
    import mep_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mep_job_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == FULL_CNT);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_data    = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_push_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/mep_core.sv =====
// back end: escape-time iteration engine with result register
module mep_core (
    input  logic                clk,
    input  logic                rst_n,
    input  mep_pkg::mep_cfg_t   cfg,
    input  mep_pkg::mep_qstat_t qstat,
    input  mep_pkg::mep_job_t   job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mep_pkg::mep_out_t   out_data
);
    import mep_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [15:0]        n_reg;
    logic [15:0]        n_next;
    logic               in_set_reg;
    logic               in_set_next;
    logic [10:0]        px_reg;
    logic [10:0]        py_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] zx_reg;
    logic signed [31:0] zx_next;
    logic signed [31:0] zy_reg;
    logic signed [31:0] zy_next;
    logic signed [31:0] x2_reg;
    logic signed [31:0] y2_reg;
    logic signed [31:0] xy_reg;
    logic signed [63:0] mul_xx;
    logic signed [63:0] mul_yy;
    logic signed [63:0] mul_xy;
    logic signed [32:0] mag2;
    logic               escaped;
    logic [15:0]        n_inc;
    logic               out_valid_reg;
    logic               out_valid_next;
    mep_out_t           out_data_reg;
    logic               out_free;
    logic               out_load;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign pop       = (state_reg == S_IDLE) && !qstat.empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // squares and cross term of z
    assign mul_xx = zx_reg * zx_reg;
    assign mul_yy = zy_reg * zy_reg;
    assign mul_xy = zx_reg * zy_reg;

    // escape test on the exact sum, then next z
    assign mag2    = 33'(x2_reg) + 33'(y2_reg);
    assign escaped = mag2 >= $signed({2'b00, cfg.escape_radius_squared});
    assign n_inc   = n_reg + 1'b1;
    assign zx_next = sat32(64'(x2_reg) - 64'(y2_reg) + 64'(cx_reg));
    assign zy_next = sat32(64'(xy_reg) + 64'(xy_reg) + 64'(cy_reg));

    // iteration sequencer
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        in_set_next = in_set_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    n_next      = '0;
                    in_set_next = (cfg.iteration_limit == '0);
                    state_next  = (cfg.iteration_limit == '0) ? S_DONE : S_MUL;
                end
            end
            S_MUL:
                state_next = S_UPD;
            S_UPD:
            begin
                if (escaped)
                begin
                    in_set_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    n_next = n_inc;
                    if (n_inc == cfg.iteration_limit)
                    begin
                        in_set_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        in_set_reg <= in_set_next;
        if (pop)
        begin
            px_reg <= job.pixel_x;
            py_reg <= job.pixel_y;
            cx_reg <= job.cx;
            cy_reg <= job.cy;
            zx_reg <= job.cx;
            zy_reg <= job.cy;
        end
        if (state_reg == S_MUL)
        begin
            x2_reg <= sat32(mul_xx >>> FRAC_BITS);
            y2_reg <= sat32(mul_yy >>> FRAC_BITS);
            xy_reg <= sat32(mul_xy >>> FRAC_BITS);
        end
        if ((state_reg == S_UPD) && !escaped)
        begin
            zx_reg <= zx_next;
            zy_reg <= zy_next;
        end
        if (out_load)
        begin
            out_data_reg.out_pixel_x  <= px_reg;
            out_data_reg.out_pixel_y  <= py_reg;
            out_data_reg.escape_count <= n_reg;
            out_data_reg.in_set       <= in_set_reg;
        end
    end

`ifndef SYNTHESIS
    a_mul_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_UPD))
        else $error("multiply cycle not followed by update");

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) || (state_reg == S_UPD)) |-> (n_reg < cfg.iteration_limit))
        else $error("iteration count reached limit while busy");

    a_in_set_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_data_reg.in_set == ($past(n_reg) == $past(cfg.iteration_limit))))
        else $error("in-set flag disagrees with count");
`endif

endmodule

// ===== tb/sv/mandelbrot_escape_time_pixel_unit_checker.sv =====
// channel watcher for the mandelbrot pixel unit: escape-time prediction and result comparison
module mandelbrot_escape_time_pixel_unit_checker #(
    parameter int unsigned IMAGE_WIDTH  = mep_pkg::DEF_IMAGE_WIDTH,
    parameter int unsigned IMAGE_HEIGHT = mep_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  mep_pkg::mep_in_t                  in_data,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  mep_pkg::mep_out_t                 out_data,
    input  logic                              cfg_we,
    input  logic [mep_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                outstanding,
    output int                                mismatches
);

    // local copy of the view registers
    logic signed [31:0] view_center_x;
    logic signed [31:0] view_center_y;
    logic [30:0]        view_step_x;
    logic [30:0]        view_step_y;
    logic [15:0]        view_limit;
    logic [30:0]        view_radius2;

    mep_pkg::mep_out_t  expected_results[$];
    mep_pkg::mep_out_t  want;
    int                 error_total = 0;

    assign mismatches = error_total;

    // clamp into the signed 32-bit range
    function automatic logic signed [31:0] clamp_q(input longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // q4.28 product, floor of the exact value, then clamped
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp_q(p >>> mep_pkg::FRAC_BITS);
    endfunction

    // pixel index to complex coordinate on one axis, half-step exact
    function automatic logic signed [31:0] pixel_to_point(input logic [10:0] pix,
                                                          input int unsigned size,
                                                          input logic [30:0] stride,
                                                          input logic signed [31:0] mid);
        longint off2;
        longint span;
        off2 = 2 * longint'(pix) - longint'(size);
        span = off2 * longint'(stride);
        return clamp_q((span >>> 1) + longint'(mid));
    endfunction

    // full escape-time evaluation of one pixel under the current view
    function automatic mep_pkg::mep_out_t escape_time(input mep_pkg::mep_in_t px);
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] zx;
        logic signed [31:0] zy;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] xy;
        int unsigned        n;
        bit                 escaped;
        mep_pkg::mep_out_t  r;
        cx = pixel_to_point(px.pixel_x, IMAGE_WIDTH, view_step_x, view_center_x);
        cy = pixel_to_point(px.pixel_y, IMAGE_HEIGHT, view_step_y, view_center_y);
        zx = cx;
        zy = cy;
        n = 0;
        escaped = 1'b0;
        while (n < view_limit && !escaped)
        begin
            x2 = fx_mul(zx, zx);
            y2 = fx_mul(zy, zy);
            xy = fx_mul(zx, zy);
            // escape test uses the unclamped sum
            if (longint'(x2) + longint'(y2) >= longint'(view_radius2))
                escaped = 1'b1;
            else
            begin
                zx = clamp_q(longint'(x2) - longint'(y2) + longint'(cx));
                zy = clamp_q(2 * longint'(xy) + longint'(cy));
                n++;
            end
        end
        r.out_pixel_x  = px.pixel_x;
        r.out_pixel_y  = px.pixel_y;
        r.escape_count = 16'(n);
        r.in_set       = (n >= view_limit);
        return r;
    endfunction

    task automatic report_error(input string msg);
        error_total++;
        if (error_total <= 100)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // track register writes, predict accepted items, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_center_x = mep_pkg::RST_CENTER_X;
            view_center_y = mep_pkg::RST_CENTER_Y;
            view_step_x   = mep_pkg::RST_STEP_X;
            view_step_y   = mep_pkg::RST_STEP_Y;
            view_limit    = mep_pkg::RST_ITER_LIMIT;
            view_radius2  = mep_pkg::RST_ESCAPE_RAD2;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // register writes, unknown indexes ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    mep_pkg::REG_CENTER_X:    view_center_x = $signed(cfg_data);
                    mep_pkg::REG_CENTER_Y:    view_center_y = $signed(cfg_data);
                    mep_pkg::REG_STEP_X:      view_step_x   = cfg_data[30:0];
                    mep_pkg::REG_STEP_Y:      view_step_y   = cfg_data[30:0];
                    mep_pkg::REG_ITER_LIMIT:  view_limit    = cfg_data[15:0];
                    mep_pkg::REG_ESCAPE_RAD2: view_radius2  = cfg_data[30:0];
                    default: ;
                endcase
            end

            // accepted pixel item
            if (in_valid && !in_stall)
                expected_results.push_back(escape_time(in_data));

            // accepted result item
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_error($sformatf("unexpected result x=%0d y=%0d n=%0d set=%0b",
                                           out_data.out_pixel_x, out_data.out_pixel_y,
                                           out_data.escape_count, out_data.in_set));
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.out_pixel_x  !== want.out_pixel_x  ||
                        out_data.out_pixel_y  !== want.out_pixel_y  ||
                        out_data.escape_count !== want.escape_count ||
                        out_data.in_set       !== want.in_set)
                        report_error($sformatf(
                            "got x=%0d y=%0d n=%0d set=%0b, want x=%0d y=%0d n=%0d set=%0b",
                            out_data.out_pixel_x, out_data.out_pixel_y,
                            out_data.escape_count, out_data.in_set,
                            want.out_pixel_x, want.out_pixel_y,
                            want.escape_count, want.in_set));
                end
            end

            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/sv/mandelbrot_escape_time_pixel_unit_test.sv =====
// testbench top for the mandelbrot pixel unit: clock, reset, stimulus, pacing and verdict
module mandelbrot_escape_time_pixel_unit_test;

    localparam int unsigned IMG_W = mep_pkg::DEF_IMAGE_WIDTH;
    localparam int unsigned IMG_H = mep_pkg::DEF_IMAGE_HEIGHT;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 40;

    // q4.28 and register extremes
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic [30:0]        Q_FOUR  = 31'h4000_0000;
    localparam logic [30:0]        U31_MAX = 31'h7FFF_FFFF;
    localparam logic [mep_pkg::CFG_INDEX_W-1:0] REG_SPARE = mep_pkg::REG_ESCAPE_RAD2 + 3'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_stall;
    mep_pkg::mep_in_t  in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    mep_pkg::mep_out_t out_data;
    logic              cfg_we = 1'b0;
    logic [mep_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int outstanding;
    int mismatches;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    mandelbrot_escape_time_pixel_unit #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mandelbrot_escape_time_pixel_unit_checker #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    // clock and reset
    always #2 clk = ~clk;

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // hard stop
    initial
    begin
        #8000000;
        $display("mandelbrot_escape_time_pixel_unit_test: errors");
        $finish;
    end

    function automatic mep_pkg::mep_in_t make_pixel(input int x, input int y);
        mep_pkg::mep_in_t p;
        p.pixel_x = 11'(x);
        p.pixel_y = 11'(y);
        return p;
    endfunction

    // mostly inside the image, now and then anywhere in the index range
    function automatic mep_pkg::mep_in_t rand_pixel(input bit wide);
        mep_pkg::mep_in_t p;
        if (wide || $urandom_range(99) < 15)
            p = make_pixel($urandom_range(2047), $urandom_range(2047));
        else
            p = make_pixel($urandom_range(IMG_W - 1), $urandom_range(IMG_H - 1));
        return p;
    endfunction

    // offer one item after a random gap, return once it is taken
    task automatic send_pixel(input mep_pkg::mep_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all six view registers, then one unused index that must be ignored
    task automatic set_view(input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic [30:0] sx, input logic [30:0] sy,
                            input logic [15:0] lim, input logic [30:0] rad2);
        cfg_we    <= 1'b1;
        cfg_index <= mep_pkg::REG_CENTER_X;
        cfg_data  <= cx;
        @(posedge clk);
        cfg_index <= mep_pkg::REG_CENTER_Y;
        cfg_data  <= cy;
        @(posedge clk);
        cfg_index <= mep_pkg::REG_STEP_X;
        cfg_data  <= {1'($urandom_range(1)), sx};
        @(posedge clk);
        cfg_index <= mep_pkg::REG_STEP_Y;
        cfg_data  <= {1'($urandom_range(1)), sy};
        @(posedge clk);
        cfg_index <= mep_pkg::REG_ITER_LIMIT;
        cfg_data  <= {16'($urandom), lim};
        @(posedge clk);
        cfg_index <= mep_pkg::REG_ESCAPE_RAD2;
        cfg_data  <= {1'($urandom_range(1)), rad2};
        @(posedge clk);
        cfg_index <= REG_SPARE + 3'($urandom_range(1));
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int ph;
        logic [15:0] lim;
        logic [30:0] rad2;

        while (!rst_n)
            @(posedge clk);

        // reset view: corners, a point deep in the set, a few ordinary pixels
        send_idle_pct = 21;
        recv_idle_pct = 80;
        send_pixel(make_pixel(0, 0));
        send_pixel(make_pixel(2047, 2047));
        send_pixel(make_pixel(2047, 0));
        send_pixel(make_pixel(0, 2047));
        send_pixel(make_pixel(512, 512));
        send_pixel(make_pixel(1023, 511));
        send_pixel(make_pixel(700, 300));

        // zero step pins every pixel to the origin, which never escapes
        settle();
        set_view(0, 0, 0, 0, 16'hFFFF, Q_FOUR);
        send_pixel(make_pixel(2047, 5));

        // no passes allowed
        settle();
        set_view(mep_pkg::RST_CENTER_X, 0, mep_pkg::RST_STEP_X, mep_pkg::RST_STEP_Y, 0, Q_FOUR);
        send_pixel(make_pixel(512, 512));
        send_pixel(make_pixel(100, 900));

        // one pass: zero radius escapes at once, widest radius does not
        settle();
        set_view(mep_pkg::RST_CENTER_X, 0, mep_pkg::RST_STEP_X, mep_pkg::RST_STEP_Y, 1, 0);
        send_pixel(make_pixel(300, 400));
        settle();
        set_view(mep_pkg::RST_CENTER_X, 0, mep_pkg::RST_STEP_X, mep_pkg::RST_STEP_Y, 1, U31_MAX);
        send_pixel(make_pixel(300, 400));

        // saturating views: extreme centers and steps
        settle();
        set_view(Q_MAX, Q_MIN, U31_MAX, U31_MAX, 16, U31_MAX);
        send_pixel(make_pixel(2047, 0));
        send_pixel(make_pixel(0, 2047));
        send_pixel(make_pixel(1024, 1024));
        settle();
        set_view(Q_MIN, Q_MAX, U31_MAX, 1, 16, Q_FOUR);
        send_pixel(make_pixel(0, 0));
        send_pixel(make_pixel(2047, 2047));

        // random views, mostly around the set, every fourth one wild
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph < PHASES / 3)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 80;
            end
            else if (ph < 2 * PHASES / 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            if (ph % 4 == 3)
                set_view($urandom, $urandom, 31'($urandom), 31'($urandom),
                         16'($urandom_range(32, 1)), 31'($urandom));
            else
            begin
                lim  = (ph == 5) ? 16'd256 : (ph == 2) ? 16'd1 : 16'($urandom_range(64, 2));
                rad2 = (ph == 6) ? 31'($urandom) : Q_FOUR;
                set_view(-536870912 + $urandom_range(805306368),
                         -402653184 + $urandom_range(805306368),
                         31'($urandom_range(2097152, 65536)),
                         31'($urandom_range(2097152, 65536)),
                         lim, rad2);
            end
            repeat (PHASE_ITEMS) send_pixel(rand_pixel(ph % 4 == 3));
        end

        settle();
        if (mismatches == 0)
            $display("mandelbrot_escape_time_pixel_unit_test: clean");
        else
            $display("mandelbrot_escape_time_pixel_unit_test: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mep_pkg.sv
rtl/mep_front.sv
rtl/mep_queue.sv
rtl/mep_core.sv
rtl/mandelbrot_escape_time_pixel_unit.sv
tb/sv/mandelbrot_escape_time_pixel_unit_checker.sv
tb/sv/mandelbrot_escape_time_pixel_unit_test.sv
